// ===== design/tsd_pkg.sv =====
// Package for the three-digit seven-segment driver: widths, codes, reciprocal
// constants and the segment decode function.
// No dependencies; the interfaces and all modules take their types from here.
package tsd_pkg;

  localparam int unsigned ValueWidth   = 20;
  localparam int unsigned CodeWidth    = 4;
  localparam int unsigned SegWidth     = 7;
  localparam int unsigned NumDigits    = 3;
  localparam int unsigned IntervalWidth = 8;
  localparam int unsigned SatWidth     = 17;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [CodeWidth-1:0] BLANK_CODE = 4'd15;
  localparam logic [SegWidth-1:0]  SEG_OFF    = 7'h7f;
  localparam logic [IntervalWidth-1:0] INTERVAL_RESET = 8'd2;

  // Saturation point and range limits, in hundredths
  localparam logic [SatWidth-1:0] SAT_HUNDREDTHS = 17'd99900;
  localparam logic [SatWidth-1:0] LIMIT_HUNDREDS = 17'd10000;
  localparam logic [SatWidth-1:0] LIMIT_TENS     = 17'd1000;

  // Reciprocals for truncating division of a value up to 99900
  localparam logic [17:0] RECIP_10    = 18'd104858;  // 2^20 / 10, rounded up
  localparam logic [17:0] RECIP_100   = 18'd167773;  // 2^24 / 100, rounded up
  localparam logic [17:0] RECIP_1000  = 18'd134218;  // 2^27 / 1000, rounded up
  localparam logic [17:0] RECIP_10000 = 18'd107375;  // 2^30 / 10000, rounded up

  // Scan positions
  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_LAST  = 2'd2;
  localparam logic [1:0] POS_BAD   = 2'd3;

  typedef struct packed {
    logic [NumDigits-1:0][CodeWidth-1:0] codes;
    logic [NumDigits-1:0]                points;
  } digits_t;

  // Active-low pattern of one digit code; anything above 9 is blank
  function automatic logic [SegWidth-1:0] seg_pattern(input logic [CodeWidth-1:0] code);
    logic [SegWidth-1:0] pat;
    unique case (code)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h10;
      default: pat = SEG_OFF;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/tsd_if.sv =====
// Valid/ready channel interfaces for the seven-segment driver: input items
// and result items. Depends on tsd_pkg for field widths.
interface tsd_item_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [tsd_pkg::ValueWidth-1:0]    value_hundredths;

  modport source (output valid, output opcode, output value_hundredths, input ready);
  modport sink   (input valid, input opcode, input value_hundredths, output ready);
endinterface

interface tsd_result_if;
  logic                              valid;
  logic                              ready;
  logic [tsd_pkg::SegWidth-1:0]      segments_n;
  logic                              point_n;
  logic [tsd_pkg::NumDigits-1:0]     digit_enable;

  modport source (output valid, output segments_n, output point_n, output digit_enable,
                  input ready);
  modport sink   (input valid, input segments_n, input point_n, input digit_enable,
                  output ready);
endinterface

// ===== design/tsd_split.sv =====
// Auto-ranging split of a value in hundredths into three decimal digit codes
// and point flags. Depends on tsd_pkg; purely combinational.
module tsd_split (
  input  logic [tsd_pkg::ValueWidth-1:0] value,
  output tsd_pkg::digits_t               digits
);
  import tsd_pkg::*;

  logic [SatWidth-1:0] sat;
  logic [34:0] p10, p100, p1000, p10000;
  logic [13:0] q10;
  logic [9:0]  q100;
  logic [6:0]  q1000;
  logic [3:0]  q10000;
  logic [SatWidth-1:0] rem_hundredth;
  logic [13:0] rem_tenth;
  logic [9:0]  rem_unit;
  logic [6:0]  rem_ten;

  // Clamp to 999.00
  assign sat = (value > ValueWidth'(SAT_HUNDREDTHS)) ? SAT_HUNDREDTHS : value[SatWidth-1:0];

  // Truncating quotients by reciprocal multiply, all in parallel
  assign p10    = 35'(sat) * 35'(RECIP_10);
  assign p100   = 35'(sat) * 35'(RECIP_100);
  assign p1000  = 35'(sat) * 35'(RECIP_1000);
  assign p10000 = 35'(sat) * 35'(RECIP_10000);
  assign q10    = p10[33:20];
  assign q100   = p100[33:24];
  assign q1000  = p1000[33:27];
  assign q10000 = p10000[33:30];

  // Each digit is a quotient less ten times the next coarser quotient
  assign rem_hundredth = sat - SatWidth'(q10) * SatWidth'(10);
  assign rem_tenth     = q10 - 14'(q100) * 14'd10;
  assign rem_unit      = q100 - 10'(q1000) * 10'd10;
  assign rem_ten       = q1000 - 7'(q10000) * 7'd10;

  // Pick the three digits and the point by range
  always_comb begin
    digits.points = '0;
    if (sat >= LIMIT_HUNDREDS) begin
      digits.codes[0] = q10000;
      digits.codes[1] = rem_ten[CodeWidth-1:0];
      digits.codes[2] = rem_unit[CodeWidth-1:0];
    end else if (sat >= LIMIT_TENS) begin
      digits.codes[0] = rem_ten[CodeWidth-1:0];
      digits.codes[1] = rem_unit[CodeWidth-1:0];
      digits.codes[2] = rem_tenth[CodeWidth-1:0];
      digits.points[1] = 1'b1;
    end else begin
      digits.codes[0] = rem_unit[CodeWidth-1:0];
      digits.codes[1] = rem_tenth[CodeWidth-1:0];
      digits.codes[2] = rem_hundredth[CodeWidth-1:0];
      digits.points[0] = 1'b1;
    end
  end

endmodule

// ===== design/three_digit_seven_segment_mux.sv =====
// Top level of the three-digit multiplexed seven-segment driver: state
// update, scan and a two-entry result buffer. Depends on tsd_pkg, tsd_if, tsd_split.
//
//   channel   dir   beat contents
//   item      in    opcode (tick / load), value_hundredths
//   result    out   segments_n, point_n, digit_enable
//   cfg       in    cfg_write, cfg_data (refresh_interval)
//
// One item per cycle while item.ready is high: each accepted beat updates the
// state and produces its result in the same cycle, registered in the result stage.
// The result is registered in the main entry, or in the skid entry while the main entry is full and not taken.
// The result stage holds two beats; item.ready drops only while both are full.
// Reset is synchronous: digits blank, scan at digit 0, nothing lit, interval 2.
module three_digit_seven_segment_mux (
  input  logic                                clk,
  input  logic                                rst,
  tsd_item_if.sink                            item,
  tsd_result_if.source                        result,
  input  logic                                cfg_write,
  input  logic [tsd_pkg::IntervalWidth-1:0]   cfg_data
);
  import tsd_pkg::*;

  localparam int unsigned ResWidth = SegWidth + 1 + NumDigits;

  logic [IntervalWidth-1:0] refresh_interval;
  digits_t                  digits, digits_next, loaded;
  logic [1:0]               scan_position, scan_position_next;
  logic [IntervalWidth-1:0] tick_count, tick_count_next, tick_inc;
  logic                     lit_flag, lit_flag_next;

  logic                     accept, fire_out;
  logic [ResWidth-1:0]      res_new, main_data, skid_data;
  logic                     main_valid, skid_valid;

  assign accept   = item.valid && item.ready;
  assign fire_out = result.valid && result.ready;
  assign item.ready = !skid_valid;

  tsd_split u_split (
    .value  (item.value_hundredths),
    .digits (loaded)
  );

  // Next state for one beat: load new digits or count a tick
  always_comb begin
    digits_next        = digits;
    scan_position_next = scan_position;
    tick_count_next    = tick_count;
    lit_flag_next      = lit_flag;
    tick_inc           = tick_count + 8'd1;
    if (item.opcode == OP_LOAD) begin
      digits_next = loaded;
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= refresh_interval) begin
        tick_count_next    = '0;
        scan_position_next = (scan_position >= POS_LAST) ? POS_FIRST : scan_position + 2'd1;
        lit_flag_next      = 1'b1;
      end
    end
  end

  // Drive of the scanned digit after this beat
  always_comb begin
    if (!lit_flag_next || scan_position_next == POS_BAD) begin
      res_new = {SEG_OFF, 1'b1, 3'b000};
    end else begin
      res_new = {seg_pattern(digits_next.codes[scan_position_next]),
                 !digits_next.points[scan_position_next],
                 3'(3'b001 << scan_position_next)};
    end
  end

  // Hold state and the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval <= INTERVAL_RESET;
      for (int i = 0; i < NumDigits; i++) begin
        digits.codes[i] <= BLANK_CODE;
      end
      digits.points <= '0;
      scan_position <= POS_FIRST;
      tick_count    <= '0;
      lit_flag      <= 1'b0;
    end else begin
      if (cfg_write) begin
        refresh_interval <= cfg_data;
      end
      if (accept) begin
        digits        <= digits_next;
        scan_position <= scan_position_next;
        tick_count    <= tick_count_next;
        lit_flag      <= lit_flag_next;
      end
    end
  end

  // Result stage with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!main_valid || fire_out) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (fire_out) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!main_valid || fire_out) begin
        main_data <= res_new;
      end else begin
        skid_data <= res_new;
      end
    end else if (fire_out && skid_valid) begin
      main_data <= skid_data;
    end
  end

  assign result.valid        = main_valid;
  assign result.segments_n   = main_data[ResWidth-1 -: SegWidth];
  assign result.point_n      = main_data[NumDigits];
  assign result.digit_enable = main_data[NumDigits-1:0];

  // Skid entry is only used behind a full main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry full while main entry empty");

  // Scan never reaches the unused position
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_position != POS_BAD)
    else $error("scan position out of range");

  // An unlit result drives everything off
  a_dark_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.digit_enable == 3'b000)
      |-> (result.segments_n == SEG_OFF && result.point_n))
    else $error("segments driven with no digit enabled");

  // Once lit, the display stays lit
  a_lit_sticky: assert property (@(posedge clk) disable iff (rst)
    lit_flag |=> lit_flag)
    else $error("lit flag cleared without reset");

endmodule

// ===== dv/tb_three_digit_seven_segment_mux.sv =====
`timescale 1ns / 1ps
// Testbench for three_digit_seven_segment_mux: random tick and load beats are
// predicted by a small scoreboard class and checked field by field against the
// result channel. Depends on tsd_pkg, tsd_if and the driver top level.
module tb_three_digit_seven_segment_mux;
  import tsd_pkg::*;

  localparam int unsigned CLIPPED_CENTS  = 99900;
  localparam int unsigned HUNDREDS_FLOOR = 10000;
  localparam int unsigned TENS_FLOOR     = 1000;
  localparam logic [3:0]  BLANK_DIGIT    = 4'd15;
  localparam logic [6:0]  DARK_GLYPH     = 7'h7f;
  localparam logic [6:0]  GLYPH [10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                         7'h12, 7'h02, 7'h78, 7'h00, 7'h10};
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned LONG_HOLD      = 60;

  typedef struct packed {
    logic [6:0] seg;
    logic       pt;
    logic [2:0] en;
  } drive_t;

  // Display state mirror and queue of expected segment drives
  class display_scoreboard;
    logic [3:0] digit_code [3];
    logic       digit_point [3];
    logic [1:0] scan_pos;
    logic [7:0] ms_count;
    logic       lit;
    logic [7:0] refresh_ms;
    drive_t     expected_q [$];
    int         mismatches;
    int         loads, ticks, advances, clipped;

    function new();
      for (int d = 0; d < 3; d++) begin
        digit_code[d]  = BLANK_DIGIT;
        digit_point[d] = 1'b0;
      end
      scan_pos   = 2'd0;
      ms_count   = 8'd0;
      lit        = 1'b0;
      refresh_ms = 8'd2;
      mismatches = 0;
      loads      = 0;
      ticks      = 0;
      advances   = 0;
      clipped    = 0;
    endfunction

    // Apply one accepted beat and queue the drive it leaves on the display
    function void note_item(logic op, logic [19:0] raw);
      int unsigned cents, whole;
      drive_t      want;
      if (op == OP_LOAD) begin
        loads++;
        cents = (raw > CLIPPED_CENTS) ? CLIPPED_CENTS : raw;
        if (raw > CLIPPED_CENTS) clipped++;
        whole = cents / 100;
        digit_point = '{1'b0, 1'b0, 1'b0};
        // Auto-range: whole digits, one decimal, or two decimals
        if (cents >= HUNDREDS_FLOOR) begin
          digit_code[0] = 4'(whole / 100);
          digit_code[1] = 4'((whole / 10) % 10);
          digit_code[2] = 4'(whole % 10);
        end else if (cents >= TENS_FLOOR) begin
          digit_code[0]  = 4'(whole / 10);
          digit_code[1]  = 4'(whole % 10);
          digit_code[2]  = 4'((cents / 10) % 10);
          digit_point[1] = 1'b1;
        end else begin
          digit_code[0]  = 4'(whole);
          digit_code[1]  = 4'((cents / 10) % 10);
          digit_code[2]  = 4'(cents % 10);
          digit_point[0] = 1'b1;
        end
      end else begin
        ticks++;
        ms_count = ms_count + 8'd1;
        // Advance the scan once the interval has elapsed; zero acts like one
        if (ms_count >= refresh_ms) begin
          ms_count = 8'd0;
          scan_pos = (scan_pos >= 2'd2) ? 2'd0 : scan_pos + 2'd1;
          lit      = 1'b1;
          advances++;
        end
      end
      if (!lit || scan_pos > 2'd2) begin
        want = '{seg: DARK_GLYPH, pt: 1'b1, en: 3'b000};
      end else begin
        want.seg = (digit_code[scan_pos] < 4'd10) ? GLYPH[digit_code[scan_pos]] : DARK_GLYPH;
        want.pt  = ~digit_point[scan_pos];
        want.en  = 3'(3'b001 << scan_pos);
      end
      expected_q.push_back(want);
    endfunction

    // Compare one result beat with the oldest expected drive
    function void check_result(drive_t got);
      drive_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: unexpected result seg=%h pt=%b en=%b", $time, got.seg, got.pt, got.en);
        return;
      end
      want = expected_q.pop_front();
      if (got.seg !== want.seg) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: segments_n expected %h actual %h", $time, want.seg, got.seg);
      end
      if (got.pt !== want.pt) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: point_n expected %b actual %b", $time, want.pt, got.pt);
      end
      if (got.en !== want.en) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: digit_enable expected %b actual %b", $time, want.en, got.en);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;

  tsd_item_if   item_bus ();
  tsd_result_if result_bus ();

  display_scoreboard sb = new();

  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned src_beats    = 0;
  int unsigned sink_beats   = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  mid_ms;

  three_digit_seven_segment_mux u_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_bus),
    .result    (result_bus),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_item(input logic op, input logic [19:0] raw);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid            <= 1'b1;
    item_bus.opcode           <= op;
    item_bus.value_hundredths <= raw;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(op, raw);
    src_beats++;
    if (src_beats % 50 == 0) src_idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // Drop valid and wait until every expected drive has come back
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_interval(input logic [7:0] ms);
    cfg_write <= 1'b1;
    cfg_data  <= ms;
    @(posedge clk);
    cfg_write     <= 1'b0;
    sb.refresh_ms  = ms;
  endtask

  // Draw a value biased toward each display range and its boundaries
  function automatic logic [19:0] pick_value();
    logic [19:0] corner [10] = '{20'd0, 20'd99, 20'd100, 20'd999, 20'd1000, 20'd9999,
                                 20'd10000, 20'd99899, 20'd99900, 20'd99901};
    case ($urandom_range(0, 5))
      0:       return 20'($urandom_range(0, 999));
      1:       return 20'($urandom_range(1000, 9999));
      2:       return 20'($urandom_range(10000, 99900));
      3:       return 20'($urandom_range(99901, 20'hfffff));
      4:       return 20'($urandom());
      default: return corner[$urandom_range(0, 9)];
    endcase
  endfunction

  // One refresh setting: random ticks and loads, with a full drain midway
  task automatic run_phase(input logic [7:0] ms, input int unsigned n_items,
                           input int unsigned load_pct);
    write_interval(ms);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      if ($urandom_range(1, 100) <= load_pct) send_item(OP_LOAD, pick_value());
      else send_item(OP_TICK, 20'($urandom()));
    end
    wait_drained();
  endtask

  // Accept results with random backpressure and a couple of long holds
  task automatic drain_results();
    int unsigned hold;
    forever begin
      if (sink_beats % 50 == 0) sink_idle_on = ($urandom_range(0, 3) != 0);
      if (sink_beats == 300 || sink_beats == 1200) hold = LONG_HOLD;
      else hold = sink_idle_on ? $urandom_range(0, 4) : 0;
      if (hold != 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      sb.check_result(drive_t'{seg: result_bus.segments_n, pt: result_bus.point_n,
                               en: result_bus.digit_enable});
      sink_beats++;
    end
  endtask

  // End the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d drives outstanding", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst                       <= 1'b1;
    cfg_write                 <= 1'b0;
    cfg_data                  <= 8'd0;
    item_bus.valid            <= 1'b0;
    item_bus.opcode           <= OP_TICK;
    item_bus.value_hundredths <= 20'd0;
    result_bus.ready          <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Directed: load while dark, first refresh, each range and the clip point
    send_item(OP_LOAD, 20'd12345);
    send_item(OP_TICK, 20'hfffff);
    send_item(OP_TICK, 20'd0);
    send_item(OP_LOAD, 20'd0);
    send_item(OP_LOAD, 20'd5);
    send_item(OP_LOAD, 20'd99);
    send_item(OP_LOAD, 20'd100);
    send_item(OP_TICK, 20'd0);
    send_item(OP_TICK, 20'd0);
    send_item(OP_LOAD, 20'd999);
    send_item(OP_LOAD, 20'd1000);
    send_item(OP_LOAD, 20'd9999);
    send_item(OP_TICK, 20'd0);
    send_item(OP_TICK, 20'd0);
    send_item(OP_LOAD, 20'd10000);
    send_item(OP_LOAD, 20'd99900);
    send_item(OP_LOAD, 20'd99901);
    send_item(OP_LOAD, 20'hfffff);
    send_item(OP_LOAD, 20'd12345);
    send_item(OP_TICK, 20'd0);
    send_item(OP_TICK, 20'd0);
    send_item(OP_LOAD, 20'd1050);
    send_item(OP_TICK, 20'd0);
    send_item(OP_TICK, 20'd0);
    send_item(OP_LOAD, 20'd808);
    wait_drained();

    // Random phases over fastest, zero, slowest and mid refresh settings
    mid_ms = 8'($urandom_range(3, 40));
    run_phase(8'd1, 300, 30);
    run_phase(8'd0, 150, 30);
    run_phase(8'd255, 600, 3);
    run_phase(8'd7, 300, 25);
    run_phase(mid_ms, 300, 30);
    run_phase(8'd2, 250, 40);

    repeat (4) @(posedge clk);
    $display("Covered %0d beats: %0d loads (%0d clipped to 999), %0d ticks, %0d digit advances",
             src_beats, sb.loads, sb.clipped, sb.ticks, sb.advances);
    $display("Refresh settings 2, 1, 0, 255, 7, %0d and 2 with two long result holds", mid_ms);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
